FILE: rtl/plcl_pkg.sv
// Shared types and constants for the piecewise linear curve lookup unit.
// No dependencies; every other rtl file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package plcl_pkg;

  // Curve table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Divider: quotient bits produced one per cycle
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Request type codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_IGNITION = 1'b0;
  localparam logic CFG_COUNT    = 1'b1;

  // Result region codes
  localparam logic [1:0] REGION_NONE   = 2'd0;
  localparam logic [1:0] REGION_EXACT  = 2'd1;
  localparam logic [1:0] REGION_INTERP = 2'd2;
  localparam logic [1:0] REGION_HOLD   = 2'd3;

  // Command classes queued by the front
  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_ZERO
  } cmd_t;

  typedef struct packed {
    cmd_t          kind;
    logic [AW-1:0] idx;
    logic [31:0]   a;   // point time, or relative query time
    logic [31:0]   b;   // point thrust
  } queue_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_MUL,
    BK_DIV,
    BK_SUM,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/plcl_front.sv
// Front end: accepts requests, tracks the largest written time and classifies queries.
// Depends on plcl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plcl_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic                  in_req_type,
  input  wire logic [5:0]            in_point_index,
  input  wire logic [31:0]           in_point_time,
  input  wire logic [31:0]           in_point_thrust,
  input  wire logic [31:0]           in_query_time,
  input  wire logic [31:0]           ignition_time,
  output logic                       push,
  output plcl_pkg::queue_entry_t     entry
);

  logic [31:0] latest_time_r, latest_time_nxt;
  logic [32:0] rel_time;
  logic        idx_ok;
  logic        out_of_range;

  // Relative time and range check against the largest written time
  assign rel_time     = {in_query_time[31], in_query_time} - {ignition_time[31], ignition_time};
  assign out_of_range = rel_time[32] ||
                        ($signed(rel_time) > $signed({latest_time_r[31], latest_time_r}));
  assign idx_ok       = 32'(in_point_index) < plcl_pkg::TABLE_DEPTH;

  // Classify the request into a queue entry
  always_comb begin
    entry.idx  = plcl_pkg::AW'(in_point_index);
    entry.b    = in_point_thrust;
    push       = 1'b0;
    latest_time_nxt = latest_time_r;
    if (in_req_type == plcl_pkg::REQ_WRITE) begin
      entry.kind = plcl_pkg::CMD_WRITE;
      entry.a    = in_point_time;
      if (accept && idx_ok) begin
        push = 1'b1;
        if ($signed(in_point_time) > $signed(latest_time_r)) begin
          latest_time_nxt = in_point_time;
        end
      end
    end else begin
      entry.kind = out_of_range ? plcl_pkg::CMD_ZERO : plcl_pkg::CMD_QUERY;
      entry.a    = rel_time[31:0];
      push       = accept;
    end
  end

  // Hold the largest time written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_time_r <= '0;
    end else begin
      latest_time_r <= latest_time_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/plcl_fifo.sv
// Short command queue between the front end and the back end.
// Depends on plcl_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
module plcl_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  plcl_pkg::queue_entry_t      push_entry,
  input  wire logic                   pop,
  output plcl_pkg::queue_entry_t      head,
  output logic                        empty,
  output logic                        full
);

  plcl_pkg::queue_entry_t mem_r [plcl_pkg::QUEUE_DEPTH];
  logic [plcl_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [plcl_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [plcl_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == plcl_pkg::QCNT_W'(plcl_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == plcl_pkg::QUEUE_DEPTH - 1) ? '0
                 : wr_ptr_r + plcl_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == plcl_pkg::QUEUE_DEPTH - 1) ? '0
                 : rd_ptr_r + plcl_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + plcl_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - plcl_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/plcl_div.sv
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// The caller guarantees the quotient fits in 32 bits. Depends on plcl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plcl_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [31:0]                   rem_r;
  logic [31:0]                   lo_r;
  logic [31:0]                   div_r;
  logic [plcl_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          run_r;
  logic                          done_r;
  logic [32:0]                   trial;
  logic [32:0]                   diff;
  logic                          ge;

  // One trial subtraction per cycle
  assign trial    = {rem_r, lo_r[31]};
  assign diff     = trial - {1'b0, div_r};
  assign ge       = (trial >= {1'b0, div_r});
  assign done     = done_r;
  assign quotient = lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Shift remainder and collect quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[63:32];
      lo_r  <= dividend[31:0];
      div_r <= divisor;
      cnt_r <= plcl_pkg::DIV_CNT_W'(plcl_pkg::DIV_STEPS - 1);
    end else if (run_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      lo_r  <= {lo_r[30:0], ge};
      cnt_r <= cnt_r - plcl_pkg::DIV_CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/plcl_back.sv
// Back end: owns the curve table, walks it for queries and interpolates.
// Depends on plcl_pkg and plcl_div.
`timescale 1ns / 1ps
`default_nettype none
module plcl_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  plcl_pkg::queue_entry_t     head,
  input  wire logic                  empty,
  input  wire logic [6:0]            point_count,
  output logic                       pop,
  output logic                       out_valid,
  output logic [31:0]                out_thrust,
  output logic [1:0]                 out_region
);

  plcl_pkg::back_state_t state_r, state_nxt;

  logic [31:0] time_mem [plcl_pkg::TABLE_DEPTH];
  logic [31:0] thr_mem  [plcl_pkg::TABLE_DEPTH];
  logic [31:0] rd_time_r;
  logic [31:0] rd_thr_r;
  logic [plcl_pkg::AW-1:0] rd_addr;
  logic        mem_we;

  logic [plcl_pkg::CNT_W-1:0] n_eff;
  logic [plcl_pkg::CNT_W-1:0] i_r;
  logic [plcl_pkg::CNT_W-1:0] i_inc;
  logic [31:0] t_r;
  logic [31:0] prev_t_r;
  logic [31:0] prev_y_r;
  logic [31:0] y0_r;
  logic [31:0] dt_r;
  logic [31:0] span_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic [31:0] res_r;
  logic [1:0]  region_r;

  logic        le;
  logic        eq;
  logic [32:0] dt33;
  logic [32:0] span33;
  logic [32:0] dy33;
  logic [32:0] mag33;
  logic        div_start;
  logic        div_done;
  logic [31:0] quo;
  logic [63:0] product;
  logic [34:0] sum;
  logic [31:0] sat;

  // Clamp the configured count to the table depth
  always_comb begin
    if (32'(point_count) > plcl_pkg::TABLE_DEPTH) begin
      n_eff = plcl_pkg::CNT_W'(plcl_pkg::TABLE_DEPTH);
    end else begin
      n_eff = plcl_pkg::CNT_W'(point_count);
    end
  end

  assign i_inc  = i_r + plcl_pkg::CNT_W'(1);
  assign le     = $signed(rd_time_r) <= $signed(t_r);
  assign eq     = (rd_time_r == t_r);
  assign dt33   = {t_r[31], t_r} - {prev_t_r[31], prev_t_r};
  assign span33 = {rd_time_r[31], rd_time_r} - {prev_t_r[31], prev_t_r};
  assign dy33   = {rd_thr_r[31], rd_thr_r} - {prev_y_r[31], prev_y_r};
  assign mag33  = dy33[32] ? (33'd0 - dy33) : dy33;
  assign product = dt_r * mag_r;

  // Add signed quotient to the start thrust and saturate
  assign sum = {{3{y0_r[31]}}, y0_r} + (neg_r ? (35'd0 - {3'd0, quo}) : {3'd0, quo});
  always_comb begin
    if ($signed(sum) > $signed(35'sh0_7FFF_FFFF)) begin
      sat = 32'h7FFF_FFFF;
    end else if ($signed(sum) < -$signed(35'sh0_8000_0000)) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  plcl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plcl_pkg::BK_IDLE: begin
        if (!empty) begin
          case (head.kind)
            plcl_pkg::CMD_QUERY: begin
              state_nxt = (n_eff == '0) ? plcl_pkg::BK_DONE : plcl_pkg::BK_CHECK;
            end
            plcl_pkg::CMD_ZERO:  state_nxt = plcl_pkg::BK_DONE;
            default:             state_nxt = plcl_pkg::BK_IDLE;
          endcase
        end
      end
      plcl_pkg::BK_CHECK: begin
        if (!le) begin
          state_nxt = plcl_pkg::BK_MUL;
        end else if (eq || i_inc == n_eff) begin
          state_nxt = plcl_pkg::BK_DONE;
        end
      end
      plcl_pkg::BK_MUL:  state_nxt = plcl_pkg::BK_DIV;
      plcl_pkg::BK_DIV: begin
        if (div_done) begin
          state_nxt = plcl_pkg::BK_SUM;
        end
      end
      plcl_pkg::BK_SUM:  state_nxt = plcl_pkg::BK_DONE;
      plcl_pkg::BK_DONE: state_nxt = plcl_pkg::BK_IDLE;
      default:           state_nxt = plcl_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_valid = 1'b0;
    rd_addr   = '0;
    case (state_r)
      plcl_pkg::BK_IDLE: begin
        pop    = !empty;
        mem_we = !empty && (head.kind == plcl_pkg::CMD_WRITE);
      end
      plcl_pkg::BK_CHECK: rd_addr   = i_inc[plcl_pkg::AW-1:0];
      plcl_pkg::BK_MUL:   div_start = 1'b1;
      plcl_pkg::BK_DONE:  out_valid = 1'b1;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plcl_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[head.idx] <= head.a;
      thr_mem[head.idx]  <= head.b;
    end
    rd_time_r <= time_mem[rd_addr];
    rd_thr_r  <= thr_mem[rd_addr];
  end

  // Walk, interpolation operands and result
  always_ff @(posedge clk) begin
    case (state_r)
      plcl_pkg::BK_IDLE: begin
        t_r      <= head.a;
        i_r      <= '0;
        prev_t_r <= '0;
        prev_y_r <= '0;
        res_r    <= '0;
        region_r <= plcl_pkg::REGION_NONE;
      end
      plcl_pkg::BK_CHECK: begin
        if (le && eq) begin
          res_r    <= rd_thr_r;
          region_r <= plcl_pkg::REGION_EXACT;
        end else if (le) begin
          prev_t_r <= rd_time_r;
          prev_y_r <= rd_thr_r;
          i_r      <= i_inc;
          res_r    <= rd_thr_r;
          region_r <= plcl_pkg::REGION_HOLD;
        end else begin
          dt_r   <= dt33[31:0];
          span_r <= span33[31:0];
          mag_r  <= mag33[31:0];
          neg_r  <= dy33[32];
          y0_r   <= prev_y_r;
        end
      end
      plcl_pkg::BK_SUM: begin
        res_r    <= sat;
        region_r <= plcl_pkg::REGION_INTERP;
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  assign out_thrust = res_r;
  assign out_region = region_r;

  // Checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plcl_pkg::BK_CHECK) |-> (i_r < n_eff)) else $error("walk past curve end");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_region == plcl_pkg::REGION_NONE) |-> (out_thrust == '0))
    else $error("out of range result not zero");
  a_div_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plcl_pkg::BK_DIV && div_done) |=> (state_r == plcl_pkg::BK_SUM))
    else $error("quotient dropped");

endmodule
`default_nettype wire

FILE: rtl/piecewise_linear_curve_lookup_unit.sv
// Top level of the piecewise linear curve lookup unit: configuration registers,
// front end, command queue and back end. Depends on plcl_pkg and all plcl_* modules.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Requests enter on start/in_* and transfer when start is high and busy is low.
//   A point write stores one (time, thrust) pair and returns nothing. A query
//   returns one result on out_thrust/out_region, marked by out_valid for exactly
//   one cycle; the receiver cannot stall it.
//   Configuration (ignition time, point count) is written through cfg_we, cfg_index
//   and cfg_wdata, by the user only while the unit is idle; the unit does not check.
// Timing:
//   Requests go through a two-entry queue; busy rises only while it is full.
//   A write waits in the queue until the idle back end pops it into the table.
//   An out-of-range or empty-curve query goes from the queue straight to the
//   DONE state to strobe its result. Other queries walk the table one entry per
//   cycle (one table read port); an exact or held result is strobed when the
//   walk stops, and an interpolated one first passes through the multiply state,
//   the divider and the sum state.
// Reset:
//   rst_n clears the control state, the largest written time, the ignition
//   time and the point count. Table contents are undefined until written.
module piecewise_linear_curve_lookup_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [5:0]  in_point_index,
  input  wire logic [31:0] in_point_time,
  input  wire logic [31:0] in_point_thrust,
  input  wire logic [31:0] in_query_time,
  output logic             out_valid,
  output logic [31:0]      out_thrust,
  output logic [1:0]       out_region,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0] ignition_time_r;
  logic [6:0]  point_count_r;
  logic        accept;
  logic        push;
  logic        pop;
  logic        empty;
  logic        full;
  plcl_pkg::queue_entry_t push_entry;
  plcl_pkg::queue_entry_t head;

  assign busy   = full;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignition_time_r <= '0;
      point_count_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        plcl_pkg::CFG_IGNITION: ignition_time_r <= cfg_wdata;
        plcl_pkg::CFG_COUNT:    point_count_r   <= cfg_wdata[6:0];
        default:                point_count_r   <= point_count_r;
      endcase
    end
  end

  plcl_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_req_type     (in_req_type),
    .in_point_index  (in_point_index),
    .in_point_time   (in_point_time),
    .in_point_thrust (in_point_thrust),
    .in_query_time   (in_query_time),
    .ignition_time   (ignition_time_r),
    .push            (push),
    .entry           (push_entry)
  );

  plcl_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  plcl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (empty),
    .point_count (point_count_r),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_thrust  (out_thrust),
    .out_region  (out_region)
  );

endmodule
`default_nettype wire
